// File: sv/coclustering_similarity_core_macros.svh
// Assertion macros for the co-clustering similarity core.
// Used by the checker; needs nothing else.
`ifndef COCLUSTERING_SIMILARITY_CORE_MACROS_SVH
`define COCLUSTERING_SIMILARITY_CORE_MACROS_SVH

// same-cycle implication
`define CSIM_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("csim assertion failed");

// next-cycle implication
`define CSIM_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("csim assertion failed");

`endif

// File: sv/csim_pkg.sv
`timescale 1ns / 1ps
// Types and constants for the co-clustering similarity core.
// No dependencies.
package csim_pkg;

   localparam int PT_W      = 8;
   localparam int IT_W      = 10;
   localparam int LBL_W     = 8;
   localparam int PTS_CFG_W = 9;
   localparam int COUNT_W   = 11;
   localparam int Q_W       = 17;
   localparam int CSR_W     = 11;
   localparam int CSR_IDX_W = 1;

   localparam logic [Q_W-1:0]       Q16_ONE        = 17'h10000;
   localparam logic [PTS_CFG_W-1:0] RST_NUM_POINTS = 9'd256;
   localparam logic [COUNT_W-1:0]   RST_NUM_ITERS  = 11'd1024;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_POINTS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_ITERS  = 1'b1;

   typedef struct packed {
      logic             req_type;
      logic [PT_W-1:0]  point_a;
      logic [PT_W-1:0]  point_b;
      logic [IT_W-1:0]  iter_index;
      logic [LBL_W-1:0] label_value;
   } csim_req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] agree_count;
      logic [Q_W-1:0]     similarity_q16;
      logic               index_error;
   } csim_rsp_type;

   typedef struct packed {
      logic busy;
      logic done;
   } csim_div_stat_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DIV,
      ST_DONE
   } csim_state_type;

endpackage

// File: sv/csim_ram.sv
`timescale 1ns / 1ps
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
module csim_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr_a,
   input  logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic [WIDTH-1:0]         rdata_a,
   output logic [WIDTH-1:0]         rdata_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_a_ff;
   logic [WIDTH-1:0] rdata_b_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_a_ff <= mem[raddr_a];
      rdata_b_ff <= mem[raddr_b];
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

// File: sv/csim_div.sv
`timescale 1ns / 1ps
// Radix-2 restoring divider: quot = num * 2^16 / den, for num <= den.
// Depends on csim_pkg.
module csim_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [csim_pkg::COUNT_W-1:0]    num,
   input  logic [csim_pkg::COUNT_W-1:0]    den,
   output csim_pkg::csim_div_stat_type     stat,
   output logic [csim_pkg::Q_W-1:0]        quot
);

   localparam int CW     = csim_pkg::COUNT_W;
   localparam int QW     = csim_pkg::Q_W;
   localparam int STEP_W = $clog2(QW);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CW:0]       rem_ff, rem_in;
   logic [QW-1:0]     quot_ff, quot_in;
   logic              trial;
   logic [CW:0]       diff;

   assign trial = rem_ff >= {1'b0, den};
   assign diff  = trial ? (rem_ff - {1'b0, den}) : rem_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = (den != '0);
         done_in = (den == '0);
         step_in = '0;
         rem_in  = {1'b0, num};
         quot_in = '0;
      end else if (busy_ff) begin
         // remainder stays below den, so the shift cannot overflow
         rem_in  = {diff[CW-1:0], 1'b0};
         quot_in = {quot_ff[QW-2:0], trial};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(QW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quot      = quot_ff;

endmodule

// File: sv/coclustering_similarity_core.sv
`timescale 1ns / 1ps
// Co-clustering similarity core: label store, query walker and result register.
// Depends on csim_pkg, csim_ram and csim_div.
//
// Usage:
//   req channel (valid/ready) carries a write (store one label of one point
//   at one iteration) or a query (compare two points over num_iters).
//   rsp channel (valid/ready) returns exactly one result per request:
//   agree_count, similarity_q16 (Q1.16, truncated) and index_error.
//   csr port writes num_points (index 0) and num_iters (index 1).
// Timing and throughput:
//   writes, bad-index queries and self queries: result registered in the
//   cycle after the transfer; one such request per cycle while rsp is taken.
//   other queries: the walk is paced by the label store read ports, which
//   deliver one label pair per cycle, followed by 17 divider steps.
//   One query is in flight at a time.
// Reset clears the registers to 256 points and 1024 iterations and empties
// the result register; stored labels are undefined until written.
// A stalled rsp holds its result; req_ready stays low until it is taken.
module coclustering_similarity_core #(
   parameter int MAX_POINTS = 256,
   parameter int MAX_ITERS  = 1024,
   parameter int LABEL_BITS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  csim_pkg::csim_req_type              req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output csim_pkg::csim_rsp_type              rsp_data,
   input  logic                                csr_we,
   input  logic [csim_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [csim_pkg::CSR_W-1:0]          csr_wdata
);

   localparam int PW     = $clog2(MAX_POINTS);
   localparam int IW     = (MAX_ITERS > 1) ? $clog2(MAX_ITERS) : 1;
   localparam int ADDR_W = PW + IW;
   localparam int DEPTH  = MAX_POINTS * (2 ** IW);
   localparam int CW     = csim_pkg::COUNT_W;
   localparam int NPW    = csim_pkg::PTS_CFG_W;

   csim_pkg::csim_state_type    state_ff, state_in;
   logic [NPW-1:0]              num_points_ff, num_points_in;
   logic [CW-1:0]               num_iters_ff, num_iters_in;
   logic                        rd_valid_ff, rd_valid_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   csim_pkg::csim_rsp_type      rsp_ff, rsp_in;
   logic [CW-1:0]               k_ff, k_in;
   logic [CW-1:0]               count_ff, count_in;
   logic [PW-1:0]               pa_ff, pa_in;
   logic [PW-1:0]               pb_ff, pb_in;

   logic [NPW-1:0]              eff_points;
   logic [CW-1:0]               eff_iters;
   logic                        req_fire;
   logic                        is_query;
   logic                        pa_bad, pb_bad, it_bad;
   logic                        wr_err, q_err, self_q;
   logic                        walk_start, walk_end, issue;
   logic                        out_free;
   logic                        rsp_load;
   logic                        div_start;
   logic                        ram_we;
   logic [ADDR_W-1:0]           waddr, raddr_a, raddr_b;
   logic [LABEL_BITS-1:0]       rdata_a, rdata_b;
   csim_pkg::csim_div_stat_type div_stat;
   logic [csim_pkg::Q_W-1:0]    div_quot;

   assign eff_points = (32'(num_points_ff) < MAX_POINTS) ? num_points_ff : NPW'(MAX_POINTS);
   assign eff_iters  = (32'(num_iters_ff) < MAX_ITERS) ? num_iters_ff : CW'(MAX_ITERS);

   assign req_fire = req_valid && req_ready;
   assign is_query = (req_data.req_type == csim_pkg::REQ_QUERY);
   assign pa_bad   = {1'b0, req_data.point_a} >= eff_points;
   assign pb_bad   = {1'b0, req_data.point_b} >= eff_points;
   assign it_bad   = {1'b0, req_data.iter_index} >= eff_iters;
   assign wr_err   = pa_bad || it_bad;
   assign q_err    = pa_bad || pb_bad;
   assign self_q   = (req_data.point_a == req_data.point_b);

   assign walk_start = req_fire && is_query && !q_err && !self_q;
   assign issue      = (state_ff == csim_pkg::ST_WALK) && (k_ff != eff_iters);
   assign walk_end   = (state_ff == csim_pkg::ST_WALK) && !issue && !rd_valid_ff;
   assign out_free   = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         csim_pkg::ST_IDLE: begin
            if (walk_start) begin
               state_in = csim_pkg::ST_WALK;
            end
         end
         csim_pkg::ST_WALK: begin
            if (walk_end) begin
               state_in = csim_pkg::ST_DIV;
            end
         end
         csim_pkg::ST_DIV: begin
            if (div_stat.done && !div_stat.busy) begin
               state_in = csim_pkg::ST_DONE;
            end
         end
         csim_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = csim_pkg::ST_IDLE;
            end
         end
         default: state_in = csim_pkg::ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_ready = (state_ff == csim_pkg::ST_IDLE) && out_free;
      div_start = walk_end;
      ram_we    = req_fire && !is_query && !wr_err;
      rsp_load  = 1'b0;
      rsp_in    = rsp_ff;
      priority if ((state_ff == csim_pkg::ST_DONE) && out_free) begin
         rsp_load              = 1'b1;
         rsp_in.agree_count    = count_ff;
         rsp_in.similarity_q16 = div_quot;
         rsp_in.index_error    = 1'b0;
      end else if (req_fire && !is_query) begin
         rsp_load              = 1'b1;
         rsp_in.agree_count    = '0;
         rsp_in.similarity_q16 = '0;
         rsp_in.index_error    = wr_err;
      end else if (req_fire && q_err) begin
         rsp_load              = 1'b1;
         rsp_in.agree_count    = '0;
         rsp_in.similarity_q16 = '0;
         rsp_in.index_error    = 1'b1;
      end else if (req_fire && self_q) begin
         rsp_load              = 1'b1;
         rsp_in.agree_count    = eff_iters;
         rsp_in.similarity_q16 = csim_pkg::Q16_ONE;
         rsp_in.index_error    = 1'b0;
      end
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);
   end

   // datapath and registers
   always_comb begin
      num_points_in = num_points_ff;
      num_iters_in  = num_iters_ff;
      if (csr_we) begin
         unique case (csr_index)
            csim_pkg::CSR_NUM_POINTS: num_points_in = csr_wdata[NPW-1:0];
            csim_pkg::CSR_NUM_ITERS:  num_iters_in  = csr_wdata;
            default: ;
         endcase
      end
      rd_valid_in = issue;
      k_in        = issue ? (k_ff + 1'b1) : k_ff;
      count_in    = count_ff;
      if (rd_valid_ff && (rdata_a == rdata_b)) begin
         count_in = count_ff + 1'b1;
      end
      pa_in = pa_ff;
      pb_in = pb_ff;
      if (walk_start) begin
         k_in     = '0;
         count_in = '0;
         pa_in    = PW'(req_data.point_a);
         pb_in    = PW'(req_data.point_b);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= csim_pkg::ST_IDLE;
         num_points_ff <= csim_pkg::RST_NUM_POINTS;
         num_iters_ff  <= csim_pkg::RST_NUM_ITERS;
         rd_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         num_points_ff <= num_points_in;
         num_iters_ff  <= num_iters_in;
         rd_valid_ff   <= rd_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff   <= rsp_in;
      k_ff     <= k_in;
      count_ff <= count_in;
      pa_ff    <= pa_in;
      pb_ff    <= pb_in;
   end

   // row = point, column = iteration
   assign waddr   = {PW'(req_data.point_a), IW'(req_data.iter_index)};
   assign raddr_a = {pa_ff, IW'(k_ff)};
   assign raddr_b = {pb_ff, IW'(k_ff)};

   csim_ram #(
      .WIDTH (LABEL_BITS),
      .DEPTH (DEPTH)
   ) u_label_store (
      .clock   (clock),
      .we      (ram_we),
      .waddr   (waddr),
      .wdata   (LABEL_BITS'(req_data.label_value)),
      .raddr_a (raddr_a),
      .raddr_b (raddr_b),
      .rdata_a (rdata_a),
      .rdata_b (rdata_b)
   );

   csim_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (count_ff),
      .den   (eff_iters),
      .stat  (div_stat),
      .quot  (div_quot)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: sv/csim_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the co-clustering similarity core, bound to the top.
// Depends on csim_pkg and the macro header.
`include "coclustering_similarity_core_macros.svh"

module csim_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input csim_pkg::csim_req_type req_data,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input csim_pkg::csim_rsp_type rsp_data
);

   logic rsp_stall;
   logic wr_xfer;
   logic zero_fields;
   logic sim_ok;

   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign wr_xfer     = req_valid && req_ready && (req_data.req_type == csim_pkg::REQ_WRITE);
   assign zero_fields = (rsp_data.agree_count == '0) && (rsp_data.similarity_q16 == '0);
   assign sim_ok      = rsp_data.similarity_q16 <= csim_pkg::Q16_ONE;

   `CSIM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_data))
   `CSIM_ASSERT_NEXT(a_write_rsp, clock, reset, wr_xfer, rsp_valid)
   `CSIM_ASSERT_NOW(a_err_zero, clock, reset, rsp_valid && rsp_data.index_error, zero_fields)
   `CSIM_ASSERT_NOW(a_sim_range, clock, reset, rsp_valid, sim_ok)
   `CSIM_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

endmodule

bind coclustering_similarity_core csim_checker u_checker (.*);
